FILE: hw/rtl/ssor_pkg.sv
// Shared types, constants and saturation helpers for the sparse SOR row sweep.
package ssor_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int VALUE_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int INDEX_BITS   = $clog2(VECTOR_DEPTH);
    localparam int OMEGA_BITS   = 18;
    localparam int QUO_BITS     = VALUE_BITS + FRAC_BITS;
    localparam int QCNT_BITS    = $clog2(QUO_BITS + 1);

    localparam logic [VALUE_BITS-1:0] ONE_FIXED   = VALUE_BITS'(1) << FRAC_BITS;
    localparam logic [OMEGA_BITS-1:0] OMEGA_RESET = OMEGA_BITS'(1) << FRAC_BITS;

    // Input action codes.
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_NONZERO = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // Result kinds.
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic [1:0]                   action;
        logic [INDEX_BITS-1:0]        row_index;
        logic [INDEX_BITS-1:0]        column_index;
        logic signed [VALUE_BITS-1:0] coefficient;
        logic signed [VALUE_BITS-1:0] row_rhs;
        logic                         last_in_row;
        logic signed [VALUE_BITS-1:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic                         result_kind;
        logic [INDEX_BITS-1:0]        result_index;
        logic signed [VALUE_BITS-1:0] solution_value;
        logic                         divide_fault;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDBK,
        S_MUL,
        S_ACC,
        S_RHS,
        S_DIV,
        S_QUO,
        S_XRD,
        S_DIF,
        S_REL,
        S_NEW,
        S_EMIT
    } t_state;

    // Saturate a wide signed value to the value range; the top bit flags saturation.
    function automatic logic [VALUE_BITS:0] sat_value(input logic signed [63:0] v);
        logic signed [63:0] vmax;
        logic signed [63:0] vmin;
        vmax = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
        vmin = -(64'sd1 <<< (VALUE_BITS - 1));
        if (v > vmax) begin
            sat_value = {1'b1, vmax[VALUE_BITS-1:0]};
        end else if (v < vmin) begin
            sat_value = {1'b1, vmin[VALUE_BITS-1:0]};
        end else begin
            sat_value = {1'b0, v[VALUE_BITS-1:0]};
        end
    endfunction

    // Magnitude of a signed value as an unsigned word of the same width.
    function automatic logic [VALUE_BITS-1:0] mag_value(input logic signed [VALUE_BITS-1:0] v);
        mag_value = v[VALUE_BITS-1] ? VALUE_BITS'(-v) : VALUE_BITS'(v);
    endfunction

endpackage

FILE: hw/rtl/ssor_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ssor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sparse_sor_row_sweep.sv
// Top level of the sparse SOR (Gauss-Seidel) row sweep over a stored solution vector.
//
// A load, an undefined action and a non-final diagonal nonzero finish in the idle state;
// a read-back adds a RAM read state, an off-diagonal nonzero a multiply and an accumulate
// state. The last nonzero of a row adds the quotient (rhs - sum) / diag from a restoring
// divider that makes one of its 48 bits per cycle, a read of the row's old value from the
// solution RAM, a relaxation multiply and the write-back. One item is in work at a time;
// a finished result sits in an output register while the next item is taken.
module sparse_sor_row_sweep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssor_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssor_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ssor_pkg::OMEGA_BITS-1:0] i_cfg_data
);

    localparam int VB = ssor_pkg::VALUE_BITS;
    localparam int FB = ssor_pkg::FRAC_BITS;
    localparam int IB = ssor_pkg::INDEX_BITS;
    localparam int QB = ssor_pkg::QUO_BITS;
    localparam int OB = ssor_pkg::OMEGA_BITS;

    ssor_pkg::t_state    r_state, n_state;
    ssor_pkg::t_in_item  r_item;
    ssor_pkg::t_out_item r_res;
    ssor_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic [OB-1:0]       r_omega;

    logic signed [VB-1:0] r_sum;
    logic signed [VB-1:0] r_diag;
    logic                 r_fault;

    logic [2*VB-1:0]      r_prod;
    logic                 r_pneg;
    logic [VB:0]          r_rem;
    logic [QB-1:0]        r_dvd;
    logic [ssor_pkg::QCNT_BITS-1:0] r_cnt;
    logic                 r_qneg;
    logic signed [VB-1:0] r_q;
    logic signed [VB-1:0] r_x;
    logic [VB:0]          r_dm;
    logic                 r_dn;
    logic [VB+OB-FB:0]    r_em;

    logic          accept;
    logic          mem_we;
    logic [IB-1:0] mem_waddr;
    logic [VB-1:0] mem_wdata;
    logic          mem_re;
    logic [IB-1:0] mem_raddr;
    logic [VB-1:0] mem_rdata;
    logic          out_free;

    // Solution vector store.
    ssor_ram #(
        .WIDTH(VB),
        .DEPTH(ssor_pkg::VECTOR_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_in_ready  = (r_state == ssor_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Arithmetic of the working states.
    logic [VB:0]          p_sat, s_sat, v_sat, q_sat, nx_sat;
    logic signed [63:0]   p_wide, s_wide, v_wide, q_wide, nx_wide;
    logic [VB-1:0]        xmag;
    logic [VB-1:0]        dmag;
    logic [VB:0]          rem_sh;
    logic                 rem_ge;
    logic signed [VB+1:0] d_wide;
    logic [VB+OB:0]       em_full;

    always_comb begin
        p_wide  = r_pneg ? -$signed({16'd0, r_prod[2*VB-1:FB]})
                         : $signed({16'd0, r_prod[2*VB-1:FB]});
        p_sat   = ssor_pkg::sat_value(p_wide);
        s_wide  = 64'(r_sum) + 64'($signed(p_sat[VB-1:0]));
        s_sat   = ssor_pkg::sat_value(s_wide);
        v_wide  = 64'(r_item.row_rhs) - 64'(r_sum);
        v_sat   = ssor_pkg::sat_value(v_wide);
        xmag    = ssor_pkg::mag_value($signed(mem_rdata));
        dmag    = ssor_pkg::mag_value(r_diag);
        rem_sh  = {r_rem[VB-1:0], r_dvd[QB-1]};
        rem_ge  = rem_sh >= {1'b0, dmag};
        q_wide  = r_qneg ? -$signed({16'd0, r_dvd}) : $signed({16'd0, r_dvd});
        q_sat   = ssor_pkg::sat_value(q_wide);
        d_wide  = (VB+2)'(r_q) - (VB+2)'($signed(mem_rdata));
        em_full = r_dm * r_omega;
        nx_wide = r_dn ? 64'(r_x) - 64'(r_em) : 64'(r_x) + 64'(r_em);
        nx_sat  = ssor_pkg::sat_value(nx_wide);
    end

    // Sequencer: next state and RAM port control.
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_item.row_index;
        mem_wdata = nx_sat[VB-1:0];
        mem_re    = 1'b0;
        mem_raddr = r_item.row_index;
        unique case (r_state)
            ssor_pkg::S_IDLE: begin
                mem_waddr = i_in.row_index;
                mem_wdata = i_in.load_value;
                mem_raddr = (i_in.action == ssor_pkg::ACT_READ) ? i_in.row_index
                                                                : i_in.column_index;
                if (accept) begin
                    case (i_in.action)
                        ssor_pkg::ACT_LOAD: mem_we = 1'b1;
                        ssor_pkg::ACT_READ: begin
                            mem_re  = 1'b1;
                            n_state = ssor_pkg::S_RDBK;
                        end
                        ssor_pkg::ACT_NONZERO: begin
                            if (i_in.row_index == i_in.column_index) begin
                                if (i_in.last_in_row) n_state = ssor_pkg::S_RHS;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = ssor_pkg::S_MUL;
                            end
                        end
                        default: n_state = ssor_pkg::S_IDLE;
                    endcase
                end
            end
            ssor_pkg::S_RDBK: n_state = ssor_pkg::S_EMIT;
            ssor_pkg::S_MUL:  n_state = ssor_pkg::S_ACC;
            ssor_pkg::S_ACC:  n_state = r_item.last_in_row ? ssor_pkg::S_RHS
                                                           : ssor_pkg::S_IDLE;
            ssor_pkg::S_RHS:  n_state = (r_diag == '0) ? ssor_pkg::S_XRD : ssor_pkg::S_DIV;
            ssor_pkg::S_DIV:  if (r_cnt == '0) n_state = ssor_pkg::S_QUO;
            ssor_pkg::S_QUO:  n_state = ssor_pkg::S_XRD;
            ssor_pkg::S_XRD: begin
                mem_re  = 1'b1;
                n_state = ssor_pkg::S_DIF;
            end
            ssor_pkg::S_DIF:  n_state = ssor_pkg::S_REL;
            ssor_pkg::S_REL:  n_state = ssor_pkg::S_NEW;
            ssor_pkg::S_NEW: begin
                mem_we  = 1'b1;
                n_state = ssor_pkg::S_EMIT;
            end
            ssor_pkg::S_EMIT: if (out_free) n_state = ssor_pkg::S_IDLE;
            default:          n_state = ssor_pkg::S_IDLE;
        endcase
    end

    // State, row accumulator, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssor_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_omega     <= ssor_pkg::OMEGA_RESET;
            r_sum       <= '0;
            r_diag      <= ssor_pkg::ONE_FIXED;
            r_fault     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_omega <= i_cfg_data;
            end
            if (accept && i_in.action == ssor_pkg::ACT_NONZERO
                    && i_in.row_index == i_in.column_index) begin
                r_diag <= i_in.coefficient;
            end
            if (r_state == ssor_pkg::S_ACC) begin
                r_sum   <= s_sat[VB-1:0];
                r_fault <= r_fault | p_sat[VB] | s_sat[VB];
            end
            if (r_state == ssor_pkg::S_NEW) begin
                r_sum   <= '0;
                r_diag  <= ssor_pkg::ONE_FIXED;
                r_fault <= 1'b0;
            end
            if (r_state == ssor_pkg::S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
        if (r_state == ssor_pkg::S_EMIT && out_free) begin
            r_out <= r_res;
        end
        unique case (r_state)
            ssor_pkg::S_RDBK: begin
                r_res.result_kind    <= ssor_pkg::KIND_READ;
                r_res.result_index   <= r_item.row_index;
                r_res.solution_value <= mem_rdata;
                r_res.divide_fault   <= 1'b0;
            end
            ssor_pkg::S_MUL: begin
                r_prod <= ssor_pkg::mag_value(r_item.coefficient) * xmag;
                r_pneg <= r_item.coefficient[VB-1] != mem_rdata[VB-1];
            end
            ssor_pkg::S_RHS: begin
                r_res.divide_fault <= r_fault | v_sat[VB] | (r_diag == '0);
                r_rem           <= '0;
                r_dvd           <= {ssor_pkg::mag_value(v_sat[VB-1:0]), FB'(0)};
                r_cnt           <= ssor_pkg::QCNT_BITS'(QB - 1);
                r_qneg          <= v_sat[VB-1] != r_diag[VB-1];
                // Zero diagonal saturates toward the numerator's sign.
                r_q <= v_sat[VB-1] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
            end
            ssor_pkg::S_DIV: begin
                r_rem <= rem_ge ? rem_sh - {1'b0, dmag} : rem_sh;
                r_dvd <= {r_dvd[QB-2:0], rem_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            ssor_pkg::S_QUO: begin
                r_q <= q_sat[VB-1:0];
                r_res.divide_fault <= r_res.divide_fault | q_sat[VB];
            end
            ssor_pkg::S_DIF: begin
                r_x  <= mem_rdata;
                r_dn <= d_wide[VB+1];
                r_dm <= d_wide[VB+1] ? (VB+1)'(-d_wide) : (VB+1)'(d_wide);
            end
            ssor_pkg::S_REL: begin
                r_em <= em_full[VB+OB:FB];
            end
            ssor_pkg::S_NEW: begin
                r_res.result_kind    <= ssor_pkg::KIND_UPDATE;
                r_res.result_index   <= r_item.row_index;
                r_res.solution_value <= nx_sat[VB-1:0];
                r_res.divide_fault   <= r_res.divide_fault | nx_sat[VB];
            end
            default: ;
        endcase
    end

endmodule

FILE: bench/sparse_sor_row_sweep_tb.sv
// Self-checking testbench for the sparse SOR row sweep: directed table, then random rows.
`timescale 1ns / 100ps

module sparse_sor_row_sweep_tb;
    import ssor_pkg::*;

    localparam longint SOL_MAX = 64'sd2147483647;
    localparam longint SOL_MIN = -64'sd2147483648;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_item i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out_item o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [OMEGA_BITS-1:0] i_cfg_data;

    // Shadow of the solution vector and of the running row.
    longint shadow_sol[VECTOR_DEPTH];
    bit sol_written[VECTOR_DEPTH];
    int written_list[$];
    longint acc_sum;
    longint acc_diag;
    bit acc_fault;
    longint omega_now;

    t_out_item pending_results[$];
    int errors;
    int items_sent;
    int results_seen;
    int faults_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_count;

    typedef struct {
        t_in_item item;
        bit typed;
        t_out_item result;
    } t_dir_row;

    t_dir_row dir_rows[$];

    sparse_sor_row_sweep DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // 20 ns clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint clamp_sol(longint v, inout bit flag);
        if (v > SOL_MAX) begin
            flag = 1'b1;
            return SOL_MAX;
        end
        if (v < SOL_MIN) begin
            flag = 1'b1;
            return SOL_MIN;
        end
        return v;
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void clear_row_state();
        acc_sum = 0;
        acc_diag = 65536;
        acc_fault = 1'b0;
    endfunction

    // Apply one accepted item to the shadow state; returns 1 when a result is due.
    function automatic bit sweep_step(t_in_item it, output t_out_item res);
        longint x, m, p, v, q, d, em, nx;
        bit f;
        res = '0;
        case (it.action)
            ACT_LOAD: begin
                shadow_sol[it.row_index] = longint'(it.load_value);
                return 1'b0;
            end
            ACT_READ: begin
                res.result_kind = KIND_READ;
                res.result_index = it.row_index;
                res.solution_value = shadow_sol[it.row_index][31:0];
                res.divide_fault = 1'b0;
                return 1'b1;
            end
            ACT_NONZERO: begin
                if (it.row_index == it.column_index) begin
                    acc_diag = longint'(it.coefficient);
                end else begin
                    x = shadow_sol[it.column_index];
                    m = (abs_of(longint'(it.coefficient)) * abs_of(x)) >>> 16;
                    p = ((it.coefficient < 0) != (x < 0)) ? -m : m;
                    p = clamp_sol(p, acc_fault);
                    acc_sum = clamp_sol(acc_sum + p, acc_fault);
                end
                if (!it.last_in_row) return 1'b0;
                f = acc_fault;
                v = clamp_sol(longint'(it.row_rhs) - acc_sum, f);
                if (acc_diag == 0) begin
                    // A zero diagonal pins the quotient to the end of the sign of the numerator.
                    f = 1'b1;
                    q = (v < 0) ? SOL_MIN : SOL_MAX;
                end else begin
                    m = (abs_of(v) <<< 16) / abs_of(acc_diag);
                    q = clamp_sol(((v < 0) != (acc_diag < 0)) ? -m : m, f);
                end
                x = shadow_sol[it.row_index];
                d = q - x;
                em = (abs_of(d) * omega_now) >>> 16;
                nx = clamp_sol(x + ((d < 0) ? -em : em), f);
                shadow_sol[it.row_index] = nx;
                res.result_kind = KIND_UPDATE;
                res.result_index = it.row_index;
                res.solution_value = nx[31:0];
                res.divide_fault = f;
                clear_row_state();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Random Q16.16 value: mostly moderate, sometimes full range or an extreme.
    function automatic logic [31:0] pick_value();
        int sel;
        logic [31:0] r;
        sel = $urandom_range(15);
        r = $urandom;
        if (sel < 4) return r;
        if (sel == 4) return 32'h7FFFFFFF;
        if (sel == 5) return 32'h80000000;
        if (sel == 6) return 32'h0;
        if (sel < 11) return 32'($signed(r[18:0]));
        return 32'($signed(r[22:0]));
    endfunction

    function automatic t_in_item blank_item();
        t_in_item it;
        it = '0;
        it.action = ACT_NONZERO;
        return it;
    endfunction

    function automatic int pick_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    // Drive one item, wait for the transfer, then update the prediction.
    task automatic send_item(t_in_item it, bit typed = 1'b0, t_out_item typed_res = '0);
        t_out_item res;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_in = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.action == ACT_LOAD && !sol_written[it.row_index]) begin
            sol_written[it.row_index] = 1'b1;
            written_list.push_back(it.row_index);
        end
        if (sweep_step(it, res)) pending_results.push_back(typed ? typed_res : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Relaxation write, only once the block has gone quiet.
    task automatic write_relaxation(logic [OMEGA_BITS-1:0] w);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_data = w;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        omega_now = longint'(w);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One random sequence: mostly well-formed rows, the rest loads, reads and noise.
    task automatic random_sequence();
        t_in_item it;
        int sel, n, r;
        sel = $urandom_range(19);
        it = blank_item();
        if (sel < 3 || written_list.size() < 4) begin
            it.action = ACT_LOAD;
            it.row_index = INDEX_BITS'($urandom);
            it.load_value = pick_value();
            it.column_index = INDEX_BITS'($urandom);
            it.coefficient = $urandom;
            it.row_rhs = $urandom;
            send_item(it);
        end else if (sel < 5) begin
            it.action = ACT_READ;
            it.row_index = INDEX_BITS'(pick_written());
            it.load_value = $urandom;
            send_item(it);
        end else if (sel == 5) begin
            it.row_index = INDEX_BITS'($urandom);
            it.column_index = INDEX_BITS'($urandom);
            it.last_in_row = 1'($urandom);
            it.row_rhs = $urandom;
            it.action = 2'd3;
            it.coefficient = $urandom;
            it.load_value = $urandom;
            send_item(it);
        end else begin
            r = pick_written();
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++) begin
                it = blank_item();
                it.row_index = INDEX_BITS'(r);
                it.coefficient = pick_value();
                it.row_rhs = pick_value();
                it.load_value = $urandom;
                if ($urandom_range(5) == 0) begin
                    it.column_index = INDEX_BITS'(r);
                    if ($urandom_range(3) == 0) it.coefficient = '0;
                end else begin
                    it.column_index = INDEX_BITS'(pick_written());
                end
                // A row left open now and then carries its sum into the next one.
                it.last_in_row = (k == n - 1) && ($urandom_range(9) != 0);
                send_item(it);
            end
        end
    endtask

    function automatic void add_row(logic [1:0] act, int row, int col, logic [31:0] coef,
                                    logic [31:0] rhs, bit last, logic [31:0] load,
                                    bit typed = 1'b0, t_out_item res = '0);
        t_dir_row d;
        d.item = '0;
        d.item.action = act;
        d.item.row_index = INDEX_BITS'(row);
        d.item.column_index = INDEX_BITS'(col);
        d.item.coefficient = coef;
        d.item.row_rhs = rhs;
        d.item.last_in_row = last;
        d.item.load_value = load;
        d.typed = typed;
        d.result = res;
        dir_rows.push_back(d);
    endfunction

    function automatic t_out_item mk_res(bit kind, int idx, logic [31:0] val, bit f);
        t_out_item r;
        r.result_kind = kind;
        r.result_index = INDEX_BITS'(idx);
        r.solution_value = val;
        r.divide_fault = f;
        return r;
    endfunction

    // Result side: random back-pressure and the field-by-field check.
    initial begin
        t_out_item want;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_out.divide_fault) faults_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result kind=%0d idx=%0d val=%h fault=%0d", $time,
                             o_out.result_kind, o_out.result_index, o_out.solution_value,
                             o_out.divide_fault);
                end else begin
                    want = pending_results.pop_front();
                    if (want.result_kind !== o_out.result_kind ||
                        want.result_index !== o_out.result_index ||
                        want.solution_value !== o_out.solution_value ||
                        want.divide_fault !== o_out.divide_fault) begin
                        errors++;
                        $display("%0t: mismatch expected kind=%0d idx=%0d val=%h fault=%0d", $time,
                                 want.result_kind, want.result_index, want.solution_value,
                                 want.divide_fault);
                        $display("%0t:          actual   kind=%0d idx=%0d val=%h fault=%0d", $time,
                                 o_out.result_kind, o_out.result_index, o_out.solution_value,
                                 o_out.divide_fault);
                    end
                end
            end
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [OMEGA_BITS-1:0] omega_plan[6];
        int target;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        faults_seen = 0;
        stall_count = 0;
        send_idle_pct = 36;
        recv_idle_pct = 78;
        omega_now = 65536;
        clear_row_state();
        foreach (shadow_sol[i]) shadow_sol[i] = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = OMEGA_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: extremes, every action and the special cases.
        add_row(ACT_LOAD, 0, 0, 0, 0, 0, 32'h7FFFFFFF);
        add_row(ACT_READ, 0, 0, 0, 0, 0, 0, 1, mk_res(KIND_READ, 0, 32'h7FFFFFFF, 0));
        add_row(ACT_LOAD, 1023, 0, 0, 0, 0, 32'h80000000);
        add_row(ACT_READ, 1023, 0, 0, 0, 0, 0, 1, mk_res(KIND_READ, 1023, 32'h80000000, 0));
        add_row(ACT_LOAD, 5, 0, 0, 0, 0, 32'h00010000);
        add_row(2'd3, 5, 7, 32'h12345678, 0, 1, 32'hFFFFFFFF);
        add_row(ACT_NONZERO, 5, 5, 0, 32'h00010000, 1, 0, 1,
                mk_res(KIND_UPDATE, 5, 32'h7FFFFFFF, 1));
        add_row(ACT_LOAD, 3, 0, 0, 0, 0, 32'hFFFF0000);
        add_row(ACT_NONZERO, 3, 3, 0, 32'h80000000, 1, 0, 1,
                mk_res(KIND_UPDATE, 3, 32'h80000000, 1));
        add_row(ACT_LOAD, 2, 0, 0, 0, 0, 32'h00030000);
        add_row(ACT_NONZERO, 2, 2, 32'h00010000, 32'h00030000, 1, 0, 1,
                mk_res(KIND_UPDATE, 2, 32'h00030000, 0));
        add_row(ACT_LOAD, 5, 0, 0, 0, 0, 32'h00020000);
        add_row(ACT_NONZERO, 5, 0, 32'h7FFFFFFF, 0, 0, 0);
        add_row(ACT_NONZERO, 5, 1023, 32'h80000000, 0, 0, 0);
        add_row(ACT_NONZERO, 5, 5, 32'h00020000, 32'h80000000, 1, 0);
        add_row(ACT_READ, 5, 0, 0, 0, 0, 0);
        add_row(ACT_NONZERO, 0, 1023, 32'hFFFFFFFF, 32'h7FFFFFFF, 1, 0);
        add_row(ACT_NONZERO, 2, 3, 32'hFFFE8000, 32'h00001000, 0, 0);
        add_row(ACT_NONZERO, 2, 2, 32'hFFFF0000, 32'hFFFFC000, 1, 0);
        add_row(ACT_READ, 2, 0, 0, 0, 0, 0);

        write_relaxation(OMEGA_RESET);
        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

        // Random part: three idle patterns, two relaxation settings each.
        omega_plan[0] = 18'd0;
        omega_plan[1] = 18'd131072;
        omega_plan[2] = 18'h3FFFF;
        omega_plan[3] = OMEGA_BITS'($urandom_range(131072));
        omega_plan[4] = 18'd32768;
        omega_plan[5] = 18'd65536;
        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_relaxation(omega_plan[seg]);
            target = items_sent + 300;
            while (items_sent < target) random_sequence();
        end

        // Drain.
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) errors++;
        $display("Sent %0d items over six relaxation settings and three idle patterns;", items_sent);
        $display("checked %0d results, %0d of them with the fault flag set.", results_seen,
                 faults_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
